### sv/sphere_ellipsoid_hit_scan_unit_macros.svh
// Assertion macros shared by the hit scan checker.
`ifndef SPHERE_ELLIPSOID_HIT_SCAN_UNIT_MACROS_SVH
`define SPHERE_ELLIPSOID_HIT_SCAN_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off during rst.
`define SEHS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during rst.
`define SEHS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/sehs_pkg.sv
// Shared types and constants of the hit scan unit.
`timescale 1ns / 1ps
package sehs_pkg;

  localparam int SLOT_COUNT = 64;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // limb engine geometry
  localparam int LIMB_W    = 32;
  localparam int X_LIMBS   = 8;
  localparam int Y_LIMBS   = 4;
  localparam int ACC_LIMBS = 12;
  localparam int XW        = X_LIMBS * LIMB_W;
  localparam int YW        = Y_LIMBS * LIMB_W;
  localparam int ACC_W     = ACC_LIMBS * LIMB_W;
  localparam int NX_W      = $clog2(X_LIMBS);
  localparam int NY_W      = $clog2(Y_LIMBS);
  localparam int OFF_W     = $clog2(ACC_LIMBS);

  localparam logic signed [31:0] MIN_ELL_RADIUS = 32'sd66;
  localparam logic signed [31:0] MIN_SCALE      = 32'sd6554;

  typedef enum logic [1:0] {
    REQ_WRITE     = 2'd0,
    REQ_SPHERE    = 2'd1,
    REQ_ELLIPSOID = 2'd2,
    REQ_NONE      = 2'd3
  } req_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] radius;
    logic [15:0]        dmg;
    logic               live;
  } slot_t;

  typedef struct packed {
    logic            start;
    logic            clear;
    logic [NX_W-1:0] nx_m1;
    logic [NY_W-1:0] ny_m1;
  } mac_ctl_t;

endpackage

### sv/sehs_cell.sv
// One slot cell of the rotating slot ring.
`timescale 1ns / 1ps
module sehs_cell (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  logic                wr_en,
  input  sehs_pkg::slot_t     wr_data,
  input  sehs_pkg::slot_t     nb_in,
  output sehs_pkg::slot_t     q
);

  always_ff @(posedge clk) begin
    if (rst) begin
      q.live <= 1'b0;
    end else if (wr_en) begin
      q <= wr_data;
    end else if (shift) begin
      q <= nb_in;
    end
  end

endmodule

### sv/sehs_mac.sv
// Limb-serial multiply-accumulate engine: acc += x * y, one 32x32 product a cycle.
`timescale 1ns / 1ps
module sehs_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  sehs_pkg::mac_ctl_t          ctl,
  input  logic [sehs_pkg::XW-1:0]     x_op,
  input  logic [sehs_pkg::YW-1:0]     y_op,
  output logic [sehs_pkg::ACC_W-1:0]  acc,
  output logic                        done
);

  logic                                running;
  logic [sehs_pkg::NX_W-1:0]           xi;
  logic [sehs_pkg::NY_W-1:0]           yj;
  logic                                last;
  logic [sehs_pkg::LIMB_W-1:0]         x_limb;
  logic [sehs_pkg::LIMB_W-1:0]         y_limb;
  logic [2*sehs_pkg::LIMB_W-1:0]       mul;
  logic [2*sehs_pkg::LIMB_W-1:0]       prod;
  logic [sehs_pkg::OFF_W-1:0]          off;
  logic                                pv;
  logic                                pl;
  logic [sehs_pkg::ACC_W-1:0]          addend;

  assign last   = (xi == ctl.nx_m1) && (yj == ctl.ny_m1);
  assign x_limb = x_op[xi*sehs_pkg::LIMB_W +: sehs_pkg::LIMB_W];
  assign y_limb = y_op[yj*sehs_pkg::LIMB_W +: sehs_pkg::LIMB_W];
  assign mul    = {{sehs_pkg::LIMB_W{1'b0}}, x_limb} * {{sehs_pkg::LIMB_W{1'b0}}, y_limb};
  assign addend = sehs_pkg::ACC_W'(prod) << (off * sehs_pkg::LIMB_W);

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      pv      <= 1'b0;
      pl      <= 1'b0;
      done    <= 1'b0;
      xi      <= '0;
      yj      <= '0;
    end else begin
      done <= pv && pl;
      pv   <= running;
      pl   <= running && last;
      if (ctl.start) begin
        running <= 1'b1;
        xi      <= '0;
        yj      <= '0;
      end else if (running) begin
        if (last) begin
          running <= 1'b0;
        end else if (xi == ctl.nx_m1) begin
          xi <= '0;
          yj <= yj + 1'b1;
        end else begin
          xi <= xi + 1'b1;
        end
      end
    end
  end

  // product stage, then shifted add into the accumulator
  always_ff @(posedge clk) begin
    prod <= mul;
    off  <= sehs_pkg::OFF_W'(xi) + sehs_pkg::OFF_W'(yj);
    if (ctl.start && ctl.clear) begin
      acc <= '0;
    end else if (pv) begin
      acc <= acc + addend;
    end
  end

endmodule

### sv/sphere_ellipsoid_hit_scan_unit.sv
// Top level of the sphere / ellipsoid hit scan unit.
//
//  Channel   Ports                                            Handshake
//  request   req_type slot coord_* size_radius scale_*        start & !busy
//            slot_damage slot_live
//  result    hit hit_x hit_y hit_z hit_damage                 done, one cycle
//
// Write and unknown requests: result one cycle after the request.
// Queries rotate the slot ring once, one step a cycle past dead slots;
// a live slot runs its test as a sequence of steps on the single 32x32
// limb multiplier, and an ellipsoid query first runs its setup steps on it.
// Reset clears every live bit at once. The receiver cannot stall; busy
// stays high from a query request until its done cycle.
`timescale 1ns / 1ps
module sphere_ellipsoid_hit_scan_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  input  logic [1:0]         req_type,
  input  logic [5:0]         slot,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic signed [31:0] size_radius,
  input  logic signed [31:0] scale_x,
  input  logic signed [31:0] scale_y,
  input  logic signed [31:0] scale_z,
  input  logic [15:0]        slot_damage,
  input  logic               slot_live,
  output logic               hit,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic signed [31:0] hit_z,
  output logic [15:0]        hit_damage
);

  localparam int N     = sehs_pkg::SLOT_COUNT;
  localparam int CW    = sehs_pkg::CNT_W;
  localparam int XW    = sehs_pkg::XW;
  localparam int YW    = sehs_pkg::YW;
  localparam int AW    = sehs_pkg::ACC_W;
  localparam int LW    = sehs_pkg::LIMB_W;
  localparam int NXW   = sehs_pkg::NX_W;
  localparam int NYW   = sehs_pkg::NY_W;

  typedef enum logic [2:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_SCAN, S_CMP, S_ALIGN
  } state_t;

  // ellipsoid setup, sphere test, ellipsoid test; each run in this order
  typedef enum logic [4:0] {
    OP_RS0, OP_RS1, OP_RS2,
    OP_SE0, OP_SE1, OP_SE2, OP_SR,
    OP_A, OP_B, OP_C, OP_E0, OP_E1, OP_E2,
    OP_T1A, OP_T1B, OP_AB, OP_L1, OP_L2, OP_R
  } op_t;

  function automatic logic [31:0] mag33(input logic [32:0] v);
    mag33 = v[32] ? 32'(-v) : v[31:0];
  endfunction

  function automatic logic [63:0] mag64(input logic [63:0] v);
    mag64 = v[63] ? -v : v;
  endfunction

  state_t             state;
  op_t                op;
  logic               is_ell;
  logic [CW-1:0]      cnt;
  logic               scan_end;
  logic               shift;
  logic               hit_cond;
  logic               op_last;

  logic signed [31:0] qx, qy, qz;
  logic [31:0]        rq;
  logic [31:0]        sc0, sc1, sc2;
  logic [63:0]        rs0, rs1, rs2;
  logic [31:0]        dm0, dm1, dm2, sm;
  logic [63:0]        av0, av1, av2;
  logic [127:0]       sqa, sqb, sqc;
  logic [63:0]        e0, e1, e2;
  logic [191:0]       t1;
  logic [255:0]       ab;
  logic [AW-1:0]      lhs;

  sehs_pkg::slot_t    ring_q  [N];
  sehs_pkg::slot_t    ring_nb [N];
  sehs_pkg::slot_t    head;
  sehs_pkg::slot_t    wr_ent;
  logic               wr_go;

  logic [32:0]        dx, dy, dz, ssum;
  logic [63:0]        srad_w, ax0, ax1, ax2;
  logic               ax_zero;

  sehs_pkg::mac_ctl_t mac_ctl;
  logic [XW-1:0]      x_op;
  logic [YW-1:0]      y_op;
  logic [AW-1:0]      acc;
  logic               mac_done;

  assign busy     = (state != S_IDLE);
  assign scan_end = (cnt == CW'(N));
  assign head     = ring_q[0];

  // slot ring
  assign wr_go = start && !busy && (req_type == sehs_pkg::REQ_WRITE) && (int'(slot) < N);

  always_comb begin
    wr_ent.pos_x  = coord_x;
    wr_ent.pos_y  = coord_y;
    wr_ent.pos_z  = coord_z;
    wr_ent.radius = size_radius;
    wr_ent.dmg    = slot_damage;
    wr_ent.live   = slot_live;
  end

  for (genvar k = 0; k < N; k++) begin : g_ring
    if (k == N - 1) begin : g_wrap
      // the head moves to the tail; a hit leaves it dead
      always_comb begin
        ring_nb[k]      = ring_q[0];
        ring_nb[k].live = ring_q[0].live && !(state == S_CMP && hit_cond);
      end
    end else begin : g_link
      assign ring_nb[k] = ring_q[k+1];
    end
    sehs_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (shift),
      .wr_en   (wr_go && (int'(slot) == k)),
      .wr_data (wr_ent),
      .nb_in   (ring_nb[k]),
      .q       (ring_q[k])
    );
  end

  // head geometry
  always_comb begin
    dx      = {head.pos_x[31], head.pos_x} - {qx[31], qx};
    dy      = {head.pos_y[31], head.pos_y} - {qy[31], qy};
    dz      = {head.pos_z[31], head.pos_z} - {qz[31], qz};
    ssum    = {1'b0, rq} + {head.radius[31], head.radius};
    srad_w  = {{16{head.radius[31]}}, head.radius, 16'h0};
    ax0     = rs0 + srad_w;
    ax1     = rs1 + srad_w;
    ax2     = rs2 + srad_w;
    ax_zero = (ax0 == '0) || (ax1 == '0) || (ax2 == '0);
  end

  assign hit_cond = is_ell ? ({lhs[AW-LW-1:0], {LW{1'b0}}} <= acc) : (lhs <= acc);

  always_comb begin
    shift = 1'b0;
    case (state)
      S_SCAN:  shift = !scan_end && (!head.live || (is_ell && ax_zero));
      S_CMP:   shift = 1'b1;
      S_ALIGN: shift = !scan_end;
      default: shift = 1'b0;
    endcase
  end

  // operand selection per step
  always_comb begin
    x_op          = '0;
    y_op          = '0;
    mac_ctl.start = (state == S_ISSUE);
    mac_ctl.clear = 1'b1;
    mac_ctl.nx_m1 = NXW'(0);
    mac_ctl.ny_m1 = NYW'(0);
    case (op)
      OP_RS0: begin x_op = XW'(rq); y_op = YW'(sc0); end
      OP_RS1: begin x_op = XW'(rq); y_op = YW'(sc1); end
      OP_RS2: begin x_op = XW'(rq); y_op = YW'(sc2); end
      OP_SE0: begin x_op = XW'(dm0); y_op = YW'(dm0); end
      OP_SE1: begin x_op = XW'(dm1); y_op = YW'(dm1); mac_ctl.clear = 1'b0; end
      OP_SE2: begin x_op = XW'(dm2); y_op = YW'(dm2); mac_ctl.clear = 1'b0; end
      OP_SR:  begin x_op = XW'(sm);  y_op = YW'(sm); end
      OP_A: begin
        x_op = XW'(av0); y_op = YW'(av0);
        mac_ctl.nx_m1 = NXW'(1); mac_ctl.ny_m1 = NYW'(1);
      end
      OP_B: begin
        x_op = XW'(av1); y_op = YW'(av1);
        mac_ctl.nx_m1 = NXW'(1); mac_ctl.ny_m1 = NYW'(1);
      end
      OP_C: begin
        x_op = XW'(av2); y_op = YW'(av2);
        mac_ctl.nx_m1 = NXW'(1); mac_ctl.ny_m1 = NYW'(1);
      end
      OP_E0: begin x_op = XW'(dm0); y_op = YW'(dm0); end
      OP_E1: begin x_op = XW'(dm1); y_op = YW'(dm1); end
      OP_E2: begin x_op = XW'(dm2); y_op = YW'(dm2); end
      OP_T1A: begin
        x_op = XW'(sqb); y_op = YW'(e0);
        mac_ctl.nx_m1 = NXW'(3); mac_ctl.ny_m1 = NYW'(1);
      end
      OP_T1B: begin
        x_op = XW'(sqa); y_op = YW'(e1); mac_ctl.clear = 1'b0;
        mac_ctl.nx_m1 = NXW'(3); mac_ctl.ny_m1 = NYW'(1);
      end
      OP_AB: begin
        x_op = XW'(sqa); y_op = YW'(sqb);
        mac_ctl.nx_m1 = NXW'(3); mac_ctl.ny_m1 = NYW'(3);
      end
      OP_L1: begin
        x_op = XW'(t1); y_op = YW'(sqc);
        mac_ctl.nx_m1 = NXW'(5); mac_ctl.ny_m1 = NYW'(3);
      end
      OP_L2: begin
        x_op = XW'(ab); y_op = YW'(e2); mac_ctl.clear = 1'b0;
        mac_ctl.nx_m1 = NXW'(7); mac_ctl.ny_m1 = NYW'(1);
      end
      OP_R: begin
        x_op = XW'(ab); y_op = YW'(sqc);
        mac_ctl.nx_m1 = NXW'(7); mac_ctl.ny_m1 = NYW'(3);
      end
      default: begin x_op = '0; y_op = '0; end
    endcase
  end

  assign op_last = (op == OP_RS2) || (op == OP_SR) || (op == OP_R);

  sehs_mac u_mac (
    .clk  (clk),
    .rst  (rst),
    .ctl  (mac_ctl),
    .x_op (x_op),
    .y_op (y_op),
    .acc  (acc),
    .done (mac_done)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
      cnt   <= '0;
      op    <= OP_RS0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            hit        <= 1'b0;
            hit_x      <= '0;
            hit_y      <= '0;
            hit_z      <= '0;
            hit_damage <= '0;
            qx         <= coord_x;
            qy         <= coord_y;
            qz         <= coord_z;
            cnt        <= '0;
            case (req_type)
              sehs_pkg::REQ_SPHERE: begin
                is_ell <= 1'b0;
                rq     <= size_radius[31] ? '0 : size_radius;
                state  <= S_SCAN;
              end
              sehs_pkg::REQ_ELLIPSOID: begin
                is_ell <= 1'b1;
                rq  <= (size_radius < sehs_pkg::MIN_ELL_RADIUS) ?
                       sehs_pkg::MIN_ELL_RADIUS : size_radius;
                sc0 <= (scale_x < sehs_pkg::MIN_SCALE) ? sehs_pkg::MIN_SCALE : scale_x;
                sc1 <= (scale_y < sehs_pkg::MIN_SCALE) ? sehs_pkg::MIN_SCALE : scale_y;
                sc2 <= (scale_z < sehs_pkg::MIN_SCALE) ? sehs_pkg::MIN_SCALE : scale_z;
                op    <= OP_RS0;
                state <= S_ISSUE;
              end
              default: done <= 1'b1;
            endcase
          end
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: begin
          if (mac_done) begin
            case (op)
              OP_RS0: rs0 <= acc[63:0];
              OP_RS1: rs1 <= acc[63:0];
              OP_RS2: rs2 <= acc[63:0];
              OP_SE2: lhs <= acc;
              OP_A:   sqa <= acc[127:0];
              OP_B:   sqb <= acc[127:0];
              OP_C:   sqc <= acc[127:0];
              OP_E0:  e0  <= acc[63:0];
              OP_E1:  e1  <= acc[63:0];
              OP_E2:  e2  <= acc[63:0];
              OP_T1B: t1  <= acc[191:0];
              OP_AB:  ab  <= acc[255:0];
              OP_L2:  lhs <= acc;
              default: ;
            endcase
            if (op_last) begin
              state <= (op == OP_RS2) ? S_SCAN : S_CMP;
            end else begin
              op    <= op_t'(op + 1'b1);
              state <= S_ISSUE;
            end
          end
        end
        S_SCAN: begin
          if (scan_end) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end else if (head.live) begin
            dm0 <= mag33(dx);
            dm1 <= mag33(dy);
            dm2 <= mag33(dz);
            sm  <= mag33(ssum);
            av0 <= mag64(ax0);
            av1 <= mag64(ax1);
            av2 <= mag64(ax2);
            // a zero ellipsoid axis never hits; shift logic skips the slot
            if (!(is_ell && ax_zero)) begin
              op    <= is_ell ? OP_A : OP_SE0;
              state <= S_ISSUE;
            end
          end
        end
        S_CMP: begin
          if (hit_cond) begin
            hit        <= 1'b1;
            hit_x      <= head.pos_x;
            hit_y      <= head.pos_y;
            hit_z      <= head.pos_z;
            hit_damage <= head.dmg;
            state      <= S_ALIGN;
          end else begin
            state <= S_SCAN;
          end
        end
        S_ALIGN: begin
          if (scan_end) begin
            done  <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
      if (shift) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

endmodule

### sv/sehs_chk.sv
// Port-level checker for the hit scan unit, bound to the top level.
`timescale 1ns / 1ps
`include "sphere_ellipsoid_hit_scan_unit_macros.svh"
module sehs_chk (
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic [1:0]         req_type,
  input logic               hit,
  input logic signed [31:0] hit_x,
  input logic signed [31:0] hit_y,
  input logic signed [31:0] hit_z,
  input logic [15:0]        hit_damage
);

  `SEHS_ASSERT_SAME(a_miss_zero, done && !hit, hit_x == 32'sd0 && hit_y == 32'sd0 && hit_z == 32'sd0 && hit_damage == 16'd0, "miss result carries nonzero data")
  `SEHS_ASSERT_NEXT(a_write_quick, start && !busy && (req_type == sehs_pkg::REQ_WRITE || req_type == sehs_pkg::REQ_NONE), done && !hit && !busy, "write request result missing")
  `SEHS_ASSERT_NEXT(a_query_busy, start && !busy && (req_type == sehs_pkg::REQ_SPHERE || req_type == sehs_pkg::REQ_ELLIPSOID), busy && !done, "query request not held busy")
  `SEHS_ASSERT_SAME(a_done_idle, done, !busy, "result shown while busy")
  `SEHS_ASSERT_SAME(a_busy_ends, $fell(busy), done, "busy dropped without a result")

endmodule

bind sphere_ellipsoid_hit_scan_unit sehs_chk u_sehs_chk (.*);

### verif/tb_sphere_ellipsoid_hit_scan_unit.sv
// Testbench for the sphere / ellipsoid hit scan unit, with a slot table predictor.
`timescale 1ns / 1ps
module tb_sphere_ellipsoid_hit_scan_unit;

  localparam int CYCLE_LIMIT = 20_000_000;
  localparam int RAND_ITEMS  = 1500;
  localparam int LIVE_CAP    = 8;

  typedef struct {
    logic        hit;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] dmg;
  } hit_result_t;

  // Slot table model plus the queue of pending hit results.
  class hit_scoreboard;
    sehs_pkg::slot_t tbl[sehs_pkg::SLOT_COUNT];
    hit_result_t     pending[$];
    int              errors, n_write, n_sphere, n_ellipsoid, n_hit;

    function new();
      foreach (tbl[k]) tbl[k] = '0;
    endfunction

    function logic [63:0] mag(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function logic [127:0] sq128(logic [63:0] m);
      logic [127:0] w;
      w = {64'b0, m};
      return w * w;
    endfunction

    function bit sphere_in(int k, longint c[3], longint r);
      logic [127:0] lhs;
      longint sum;
      lhs = sq128(mag(longint'(tbl[k].pos_x) - c[0])) +
            sq128(mag(longint'(tbl[k].pos_y) - c[1])) +
            sq128(mag(longint'(tbl[k].pos_z) - c[2]));
      sum = r + longint'(tbl[k].radius);
      return lhs <= sq128(mag(sum));
    endfunction

    function bit ellipsoid_in(int k, longint c[3], longint r, longint s[3]);
      logic [511:0] a2[3], d2[3], lhs, rhs;
      longint ax, d[3];
      d[0] = longint'(tbl[k].pos_x) - c[0];
      d[1] = longint'(tbl[k].pos_y) - c[1];
      d[2] = longint'(tbl[k].pos_z) - c[2];
      for (int i = 0; i < 3; i++) begin
        ax = r * s[i] + longint'(tbl[k].radius) * 65536;
        if (ax == 0) return 0;  // degenerate axis never hits
        a2[i] = 512'(sq128(mag(ax)));
        d2[i] = 512'(sq128(mag(d[i]))) << 32;
      end
      lhs = d2[0] * a2[1] * a2[2] + d2[1] * a2[0] * a2[2] + d2[2] * a2[0] * a2[1];
      rhs = a2[0] * a2[1] * a2[2];
      return lhs <= rhs;
    endfunction

    function int live_count();
      int n;
      n = 0;
      foreach (tbl[k]) n += tbl[k].live;
      return n;
    endfunction

    function int pick_live();
      int idx[$];
      foreach (tbl[k]) if (tbl[k].live) idx.push_back(k);
      if (idx.size() == 0) return -1;
      return idx[$urandom_range(idx.size() - 1)];
    endfunction

    // Accepted request: update the table and queue the expected result.
    function void note(sehs_pkg::req_t rt, logic [5:0] sl,
                       logic signed [31:0] cx, cy, cz, rad,
                       logic signed [31:0] scx, scy, scz, logic [15:0] dmg, logic lv);
      hit_result_t res;
      longint c[3], r, s[3];
      bit h;
      res = '{0, 0, 0, 0, 0};
      c = '{cx, cy, cz};
      r = rad;
      s = '{scx, scy, scz};
      case (rt)
        sehs_pkg::REQ_WRITE: begin
          tbl[sl] = '{cx, cy, cz, rad, dmg, lv};
          n_write++;
        end
        sehs_pkg::REQ_SPHERE, sehs_pkg::REQ_ELLIPSOID: begin
          if (rt == sehs_pkg::REQ_SPHERE) begin
            if (r < 0) r = 0;
            n_sphere++;
          end else begin
            if (r < sehs_pkg::MIN_ELL_RADIUS) r = sehs_pkg::MIN_ELL_RADIUS;
            foreach (s[i]) if (s[i] < sehs_pkg::MIN_SCALE) s[i] = sehs_pkg::MIN_SCALE;
            n_ellipsoid++;
          end
          for (int k = 0; k < sehs_pkg::SLOT_COUNT; k++) begin
            if (!tbl[k].live) continue;
            h = (rt == sehs_pkg::REQ_SPHERE) ? sphere_in(k, c, r) :
                                               ellipsoid_in(k, c, r, s);
            if (h) begin
              res = '{1, tbl[k].pos_x, tbl[k].pos_y, tbl[k].pos_z, tbl[k].dmg};
              tbl[k].live = 0;
              n_hit++;
              break;
            end
          end
        end
        default: ;
      endcase
      pending.push_back(res);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] exp);
      $display("mismatch %s: got %h expected %h at %0t", what, got, exp, $realtime);
      errors++;
    endtask

    task check(hit_result_t got);
      hit_result_t e;
      if (pending.size() == 0) begin
        report("unexpected result", got.hit, 0);
        return;
      end
      e = pending.pop_front();
      if (got.hit !== e.hit) report("hit", got.hit, e.hit);
      if (got.x !== e.x) report("hit_x", got.x, e.x);
      if (got.y !== e.y) report("hit_y", got.y, e.y);
      if (got.z !== e.z) report("hit_z", got.z, e.z);
      if (got.dmg !== e.dmg) report("hit_damage", got.dmg, e.dmg);
    endtask
  endclass

  logic clk = 0, rst = 1, start = 0;
  logic busy, done, hit, slot_live = 0;
  logic [1:0] req_type = sehs_pkg::REQ_WRITE;
  logic [5:0] slot = 0;
  logic signed [31:0] coord_x = 0, coord_y = 0, coord_z = 0, size_radius = 0;
  logic signed [31:0] scale_x = 0, scale_y = 0, scale_z = 0;
  logic [15:0] slot_damage = 0, hit_damage;
  logic signed [31:0] hit_x, hit_y, hit_z;
  hit_scoreboard sb = new();
  int cycles = 0;

  sphere_ellipsoid_hit_scan_unit dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && done) sb.check('{hit, hit_x, hit_y, hit_z, hit_damage});
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL sphere_ellipsoid_hit_scan_unit");
      $finish;
    end
  end

  task idle(int n);
    start <= 0;
    repeat (n) @(posedge clk);
  endtask

  task drain();
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Present one request and hold it until the block takes it.
  task send(sehs_pkg::req_t rt, logic [5:0] sl, logic signed [31:0] cx, cy, cz, rad,
            logic signed [31:0] scx, scy, scz, logic [15:0] dmg, logic lv);
    start <= 1;
    req_type <= rt;
    slot <= sl;
    coord_x <= cx;
    coord_y <= cy;
    coord_z <= cz;
    size_radius <= rad;
    scale_x <= scx;
    scale_y <= scy;
    scale_z <= scz;
    slot_damage <= dmg;
    slot_live <= lv;
    do @(posedge clk); while (busy);
    sb.note(rt, sl, cx, cy, cz, rad, scx, scy, scz, dmg, lv);
  endtask

  function logic signed [31:0] rnd_coord();
    if ($urandom_range(9) == 0) return $urandom;
    return $signed($urandom_range(2 ** 19)) - 2 ** 18;
  endfunction

  function logic signed [31:0] rnd_scale();
    if ($urandom_range(7) == 0) return $urandom;
    return $urandom_range(2 ** 17);
  endfunction

  task rnd_item();
    int pick, k;
    logic signed [31:0] cx, cy, cz, rad;
    pick = $urandom_range(99);
    if (pick < 55) begin
      rad = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2 ** 17);
      send(sehs_pkg::REQ_WRITE, 6'($urandom), rnd_coord(), rnd_coord(), rnd_coord(), rad,
           $urandom, $urandom, $urandom, 16'($urandom),
           sb.live_count() < LIVE_CAP ? ($urandom_range(3) != 0) : 1'b0);
    end else if (pick < 97) begin
      k = sb.pick_live();
      if (k >= 0 && $urandom_range(9) < 7) begin
        // aim close to a live projectile
        cx = sb.tbl[k].pos_x + $signed($urandom_range(2 ** 17)) - 2 ** 16;
        cy = sb.tbl[k].pos_y + $signed($urandom_range(2 ** 17)) - 2 ** 16;
        cz = sb.tbl[k].pos_z + $signed($urandom_range(2 ** 17)) - 2 ** 16;
      end else begin
        cx = rnd_coord();
        cy = rnd_coord();
        cz = rnd_coord();
      end
      rad = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2 ** 17);
      send(pick < 82 ? sehs_pkg::REQ_SPHERE : sehs_pkg::REQ_ELLIPSOID, 6'($urandom),
           cx, cy, cz, rad, rnd_scale(), rnd_scale(), rnd_scale(), 16'($urandom),
           1'($urandom));
    end else begin
      send(sehs_pkg::REQ_NONE, 6'($urandom), $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom, $urandom, 16'($urandom), 1'($urandom));
    end
  endtask

  localparam logic signed [31:0] SMAX = 32'sh7fffffff;
  localparam logic signed [31:0] SMIN = 32'sh80000000;
  localparam logic signed [31:0] ONE  = 32'sh00010000;

  initial begin
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: extremes, clamps, degenerate axis, negative radius sum
    send(sehs_pkg::REQ_SPHERE, 0, 0, 0, 0, SMAX, 0, 0, 0, 0, 0);
    send(sehs_pkg::REQ_WRITE, 0, SMAX, SMAX, SMAX, SMAX, 0, 0, 0, 16'hffff, 1);
    send(sehs_pkg::REQ_WRITE, 63, SMIN, SMIN, SMIN, SMIN, 0, 0, 0, 16'h0001, 1);
    send(sehs_pkg::REQ_WRITE, 5, 0, 0, 0, -ONE, 0, 0, 0, 16'h00a5, 1);
    send(sehs_pkg::REQ_ELLIPSOID, 0, 0, 0, 0, ONE, ONE, ONE, ONE, 0, 0);
    send(sehs_pkg::REQ_SPHERE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(sehs_pkg::REQ_WRITE, 7, 0, 0, 0, 0, 0, 0, 0, 16'h1234, 0);
    send(sehs_pkg::REQ_SPHERE, 0, 0, 0, 0, SMIN, 0, 0, 0, 0, 0);
    send(sehs_pkg::REQ_SPHERE, 0, SMAX, SMAX, SMAX, SMIN, 0, 0, 0, 0, 0);
    send(sehs_pkg::REQ_ELLIPSOID, 0, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, 0, 0);
    send(sehs_pkg::REQ_ELLIPSOID, 0, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX, SMAX, 0, 0);
    send(sehs_pkg::REQ_WRITE, 40, ONE, -ONE, ONE, ONE, 0, 0, 0, 16'h8000, 1);
    send(sehs_pkg::REQ_WRITE, 40, ONE, -ONE, ONE, ONE, 0, 0, 0, 16'h8000, 0);
    send(sehs_pkg::REQ_SPHERE, 0, ONE, -ONE, ONE, 0, 0, 0, 0, 0, 0);
    send(sehs_pkg::REQ_NONE, 6'h3f, SMIN, SMAX, -1, SMIN, SMAX, SMIN, -1, 16'hffff, 1);
    send(sehs_pkg::REQ_WRITE, 9, 1000, 2000, 3000, 0, 0, 0, 0, 16'h0042, 1);
    send(sehs_pkg::REQ_ELLIPSOID, 0, 1000, 2000, 3000, 0, 0, 0, 0, 0, 0);
    idle(1);
    drain();

    for (int i = 0; i < RAND_ITEMS; i++) begin
      if (i == RAND_ITEMS / 2) begin
        idle(1);
        drain();
      end
      if (i < RAND_ITEMS - 200 && $urandom_range(3) == 0) idle($urandom_range(1, 15));
      rnd_item();
    end
    start <= 0;

    drain();
    repeat (20) @(posedge clk);
    $display("covered %0d writes, %0d sphere and %0d ellipsoid queries, %0d hits",
             sb.n_write, sb.n_sphere, sb.n_ellipsoid, sb.n_hit);
    if (sb.errors == 0) begin
      $display("PASS sphere_ellipsoid_hit_scan_unit");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("FAIL sphere_ellipsoid_hit_scan_unit");
    end
    $finish;
  end
endmodule
